@@ hdl/bbcd_pkg.sv @@
// Shared constants, types and the coordinate mapping of the bitmap block cache directory.
`default_nettype none
package bbcd_pkg;

  // Directory geometry.
  localparam int SLOTS   = 64;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int AGE_W   = 7;
  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  // Field widths of the transactions.
  localparam int COORD_W = 12;
  localparam int BLOCK_W = 12;
  localparam int WORD_W  = 8;
  localparam int BIT_W   = 4;
  localparam int SLOT_W  = 6;
  localparam int MODE_W  = 2;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_LAYOUT_MODE = '0;

  // Block numbering layouts; the unused code behaves as the largest layout.
  localparam logic [MODE_W-1:0] LAYOUT_1K = 2'd0;
  localparam logic [MODE_W-1:0] LAYOUT_2K = 2'd1;
  localparam logic [MODE_W-1:0] LAYOUT_4K = 2'd2;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [AGE_W-1:0]   age_t;
  typedef logic [BLOCK_W-1:0] block_t;

  typedef struct packed {
    logic              func;
    block_t            block;
    logic [WORD_W-1:0] word_index;
    logic [BIT_W-1:0]  bit_index;
  } bbcd_req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] word_index;
    logic [BIT_W-1:0]  bit_index;
    logic              writeback;
    block_t            victim_block;
    block_t            fill_block;
  } bbcd_res_t;

  function automatic block_t block_of(input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y,
                                      input logic [MODE_W-1:0]  mode);
    block_t b;
    case (mode)
      LAYOUT_1K: b = {4'b0, y[9:6], x[9:6]};
      LAYOUT_2K: b = {2'b0, y[10:6], x[10:6]};
      default:   b = {y[11:6], x[11:6]};
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ hdl/bbcd_if.sv @@
// Valid/ready channel interfaces for the access and result transactions.
`default_nettype none
interface bbcd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [bbcd_pkg::COORD_W-1:0] x_coord;
  logic [bbcd_pkg::COORD_W-1:0] y_coord;

  modport source (output valid, func, x_coord, y_coord, input ready);
  modport sink   (input valid, func, x_coord, y_coord, output ready);
endinterface

interface bbcd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [bbcd_pkg::SLOT_W-1:0]  slot;
  logic [bbcd_pkg::WORD_W-1:0]  word_index;
  logic [bbcd_pkg::BIT_W-1:0]   bit_index;
  logic                         writeback;
  logic [bbcd_pkg::BLOCK_W-1:0] victim_block;
  logic [bbcd_pkg::BLOCK_W-1:0] fill_block;

  modport source (output valid, hit, slot, word_index, bit_index, writeback, victim_block,
                  fill_block, input ready);
  modport sink   (input valid, hit, slot, word_index, bit_index, writeback, victim_block,
                  fill_block, output ready);
endinterface
`default_nettype wire

@@ hdl/bbcd_cfg.sv @@
// APB-style register holding the block numbering layout.
`default_nettype none
module bbcd_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bbcd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bbcd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bbcd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [bbcd_pkg::MODE_W-1:0]       layout_mode
);
  import bbcd_pkg::*;

  logic [MODE_W-1:0]    layout_r;
  logic [MODE_W-1:0]    layout_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    layout_nxt = layout_r;
    if (wr_en && (reg_idx == REG_LAYOUT_MODE)) begin
      layout_nxt = pwdata[MODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= LAYOUT_1K;
    end else begin
      layout_r <= layout_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_LAYOUT_MODE) begin
      prdata = APB_DATA_W'(layout_r);
    end
  end

  assign layout_mode = layout_r;

endmodule
`default_nettype wire

@@ hdl/bbcd_dir.sv @@
// Slot directory with tag and age memories, scanned one slot per cycle by a small sequencer.
`default_nettype none
module bbcd_dir (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  bbcd_pkg::bbcd_req_t  req,
  output logic                 idle,
  output logic                 done,
  input  logic                 take,
  output bbcd_pkg::bbcd_res_t  res
);
  import bbcd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  // Storage.
  block_t     tag_mem [SLOTS];
  age_t       age_mem [SLOTS];
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [SLOTS-1:0] dirty_r, dirty_nxt;
  logic [SLOTS-1:0] age_ok_r, age_ok_nxt;

  // Sequencer state.
  state_t     state_r, state_nxt;
  bbcd_req_t  req_r, req_nxt;
  logic [CNT_W-1:0] raddr_r, raddr_nxt;
  logic       pv_r, pv_nxt;
  idx_t       pidx_r, pidx_nxt;
  logic       hit_r, hit_nxt;
  idx_t       slot_r, slot_nxt;
  age_t       best_r, best_nxt;
  idx_t       pick_r, pick_nxt;
  logic       vdone_r, vdone_nxt;
  logic       wb_r, wb_nxt;
  block_t     vtag_r, vtag_nxt;

  // Registered read data.
  block_t     tag_q;
  age_t       age_q;
  logic       vld_q;
  logic       aok_q;

  logic       scanning;
  logic       issue;
  idx_t       rd_addr;
  age_t       age_eff;
  age_t       age_inc;
  logic       match;
  logic       last;
  logic       age_we;
  age_t       age_wd;
  logic       tag_we;

  assign scanning = (state_r == ST_SCAN) || (state_r == ST_SWEEP);
  assign issue    = scanning && (raddr_r < CNT_W'(SLOTS));
  assign rd_addr  = raddr_r[IDX_W-1:0];
  assign age_eff  = aok_q ? age_q : AGE_W'(SLOTS - int'(pidx_r));
  assign age_inc  = (age_eff == AGE_MAX) ? age_eff : age_eff + 1'b1;
  assign match    = vld_q && (tag_q == req_r.block);
  assign last     = (pidx_r == IDX_W'(SLOTS - 1));

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    raddr_nxt  = raddr_r;
    pv_nxt     = 1'b0;
    pidx_nxt   = pidx_r;
    hit_nxt    = hit_r;
    slot_nxt   = slot_r;
    best_nxt   = best_r;
    pick_nxt   = pick_r;
    vdone_nxt  = vdone_r;
    wb_nxt     = wb_r;
    vtag_nxt   = vtag_r;
    valid_nxt  = valid_r;
    dirty_nxt  = dirty_r;
    age_ok_nxt = age_ok_r;
    age_we     = 1'b0;
    age_wd     = '0;
    tag_we     = 1'b0;

    if (issue) begin
      raddr_nxt = raddr_r + 1'b1;
      pv_nxt    = 1'b1;
      pidx_nxt  = rd_addr;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt   = req;
          raddr_nxt = '0;
          hit_nxt   = 1'b0;
          best_nxt  = '0;
          pick_nxt  = '0;
          vdone_nxt = 1'b0;
          wb_nxt    = 1'b0;
          vtag_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pv_r) begin
          if (match) begin
            // First matching slot wins; a write marks it dirty.
            hit_nxt   = 1'b1;
            slot_nxt  = pidx_r;
            dirty_nxt[pidx_r] = dirty_r[pidx_r] | req_r.func;
            pv_nxt    = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            // Oldest slot so far; the search settles on the first new oldest slot whose age is SLOTS-1.
            if (!vdone_r && (age_eff > best_r)) begin
              best_nxt = age_eff;
              pick_nxt = pidx_r;
              if (age_eff == AGE_W'(SLOTS - 1)) begin
                vdone_nxt = 1'b1;
              end
            end
            if (last) begin
              raddr_nxt = '0;
              pv_nxt    = 1'b0;
              state_nxt = ST_SWEEP;
            end
          end
        end
      end
      ST_SWEEP: begin
        if (pv_r) begin
          age_we = 1'b1;
          age_wd = (pidx_r == pick_r) ? '0 : age_inc;
          age_ok_nxt[pidx_r] = 1'b1;
          if (pidx_r == pick_r) begin
            wb_nxt   = valid_r[pick_r] & dirty_r[pick_r];
            vtag_nxt = (valid_r[pick_r] & dirty_r[pick_r]) ? tag_q : '0;
          end
          if (last) begin
            tag_we            = 1'b1;
            valid_nxt[pick_r] = 1'b1;
            dirty_nxt[pick_r] = req_r.func;
            slot_nxt          = pick_r;
            pv_nxt            = 1'b0;
            state_nxt         = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pv_r     <= 1'b0;
      valid_r  <= '0;
      dirty_r  <= '0;
      age_ok_r <= '0;
    end else begin
      state_r  <= state_nxt;
      pv_r     <= pv_nxt;
      valid_r  <= valid_nxt;
      dirty_r  <= dirty_nxt;
      age_ok_r <= age_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    raddr_r <= raddr_nxt;
    pidx_r  <= pidx_nxt;
    hit_r   <= hit_nxt;
    slot_r  <= slot_nxt;
    best_r  <= best_nxt;
    pick_r  <= pick_nxt;
    vdone_r <= vdone_nxt;
    wb_r    <= wb_nxt;
    vtag_r  <= vtag_nxt;
  end

  // Memories: one read address shared by both, registered read data.
  always_ff @(posedge clk) begin
    tag_q <= tag_mem[rd_addr];
    age_q <= age_mem[rd_addr];
    vld_q <= valid_r[rd_addr];
    aok_q <= age_ok_r[rd_addr];
    if (tag_we) begin
      tag_mem[pick_r] <= req_r.block;
    end
    if (age_we) begin
      age_mem[pidx_r] <= age_wd;
    end
  end

  assign idle = (state_r == ST_IDLE);
  assign done = (state_r == ST_FIN);

  always_comb begin
    res.hit          = hit_r;
    res.slot         = SLOT_W'(slot_r);
    res.word_index   = req_r.word_index;
    res.bit_index    = req_r.bit_index;
    res.writeback    = wb_r;
    res.victim_block = vtag_r;
    res.fill_block   = hit_r ? '0 : req_r.block;
  end

endmodule
`default_nettype wire

@@ hdl/bitmap_block_cache_directory.sv @@
// Top level of the bitmap block cache directory: access channel, result channel, register port.
`default_nettype none
// The block takes one bit access transaction (read or write at x_coord, y_coord), maps the
// coordinates to a block number, a 16-bit word and a bit under the layout chosen in the
// layout_mode register (byte address 0), and looks the block up in a fully associative
// directory of 64 slots. One slot is examined per cycle: tags and ages sit in memories with a
// single registered read port, and one compare unit walks them under a small sequencer. A hit
// at slot k ends the walk at that slot. A miss walks all 64 slots to find the oldest one, then
// makes a second pass over the age memory to age every slot and clear the victim. The block
// accepts no new access while one is in flight; the result sits in an output register, so
// the next access is accepted as soon as the current result has been handed to that register,
// even if the sink stalls.
// Replacement is first-in first-out: hits do not refresh a slot's age. A dirty victim is
// reported with writeback high and its block number in victim_block; fill_block names the
// block to load on a miss. Change layout_mode only while the block is idle.
module bitmap_block_cache_directory (
  input  logic                              clk,
  input  logic                              rst_n,
  bbcd_in_if.sink                           in_ch,
  bbcd_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bbcd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bbcd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bbcd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import bbcd_pkg::*;

  logic [MODE_W-1:0] layout_mode;
  bbcd_req_t         req;
  bbcd_res_t         dir_res;
  logic              dir_idle;
  logic              dir_done;
  logic              start;
  logic              take;

  bbcd_res_t         out_res_r, out_res_nxt;
  logic              out_vld_r, out_vld_nxt;

  bbcd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .layout_mode (layout_mode)
  );

  // Address split of the incoming access.
  always_comb begin
    req.func       = in_ch.func;
    req.block      = block_of(in_ch.x_coord, in_ch.y_coord, layout_mode);
    req.word_index = {in_ch.y_coord[5:4], in_ch.x_coord[5:0]};
    req.bit_index  = in_ch.y_coord[3:0];
  end

  assign in_ch.ready = dir_idle;
  assign start       = in_ch.valid && dir_idle;

  bbcd_dir u_dir (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .req   (req),
    .idle  (dir_idle),
    .done  (dir_done),
    .take  (take),
    .res   (dir_res)
  );

  // The finished result moves into the output register once it is free or being emptied.
  assign take = dir_done && (!out_vld_r || out_ch.ready);

  always_comb begin
    out_res_nxt = out_res_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    if (take) begin
      out_res_nxt = dir_res;
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.hit          = out_res_r.hit;
  assign out_ch.slot         = out_res_r.slot;
  assign out_ch.word_index   = out_res_r.word_index;
  assign out_ch.bit_index    = out_res_r.bit_index;
  assign out_ch.writeback    = out_res_r.writeback;
  assign out_ch.victim_block = out_res_r.victim_block;
  assign out_ch.fill_block   = out_res_r.fill_block;

endmodule
`default_nettype wire

@@ test/bitmap_block_cache_directory_tb.sv @@
// Self-checking testbench for the bitmap block cache directory: directed and random accesses.
module bitmap_block_cache_directory_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbcd_pkg::*;

  // Access kinds carried in the func field of an access transaction.
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // The fourth layout code is not assigned and must behave like the 4K layout.
  localparam logic [MODE_W-1:0] LAYOUT_SPARE = 2'd3;

  // Register index that decodes to nothing; writes there must leave layout_mode alone.
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 1'b1;

  // A miss walks the directory twice, so a result is slow; allow margin.
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int POOL_DEPTH    = 40;
  localparam int PHASE_ITEMS   = 85;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  bbcd_in_if  acc_bus ();
  bbcd_out_if res_bus ();

  bitmap_block_cache_directory i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (acc_bus.sink),
    .out_ch  (res_bus.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the directory. Tags are only looked at while their slot is valid, so the
  // reset value of the tag array does not matter.
  block_t          dir_tag   [SLOTS];
  logic            dir_valid [SLOTS];
  logic            dir_dirty [SLOTS];
  age_t            dir_age   [SLOTS];
  logic [MODE_W-1:0] layout_q;

  // Results predicted for accepted accesses, oldest first.
  bbcd_res_t pending_results[$];
  bbcd_res_t want_res;

  // Upper coordinate bits of recently used blocks, reused so that many accesses hit.
  logic [11:0] recent_blocks[$];

  int  mismatches;
  int  cycle_count;
  bit  steady;      // When set, neither side idles.
  bit  hold_req;    // Asks the result sink to hold off for HOLD_CYCLES.
  int  hold_left;

  // 20 ns clock period.
  always #10 clk = ~clk;

  // Runaway guard. It is far above the slowest correct run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still expected", $time, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result sink. It drops ready at random, except in the steady phase, and honors a long
  // hold-off request by counting it down here, independent of the access sender.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      res_bus.ready <= steady || ($urandom_range(99) >= 32);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Every result transaction is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transaction with nothing expected: expected none, actual slot %0d",
                 $time, res_bus.slot);
        mismatches++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("hit", 32'(want_res.hit), 32'(res_bus.hit));
        check_field("slot", 32'(want_res.slot), 32'(res_bus.slot));
        check_field("word_index", 32'(want_res.word_index), 32'(res_bus.word_index));
        check_field("bit_index", 32'(want_res.bit_index), 32'(res_bus.bit_index));
        check_field("writeback", 32'(want_res.writeback), 32'(res_bus.writeback));
        check_field("victim_block", 32'(want_res.victim_block), 32'(res_bus.victim_block));
        check_field("fill_block", 32'(want_res.fill_block), 32'(res_bus.fill_block));
      end
    end
  end

  // Directory lookup and first-in first-out replacement for one access. It updates the
  // shadow directory and returns the result the block must produce.
  function automatic bbcd_res_t predict_lookup(input logic f, input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y);
    bbcd_res_t r;
    block_t    blk;
    int        owner;
    int        best;
    r = '0;
    case (layout_q)
      LAYOUT_1K: blk = ((y & 12'h3C0) >> 2) | ((x & 12'h3C0) >> 6);
      LAYOUT_2K: blk = ((y & 12'h7C0) >> 1) | ((x & 12'h7C0) >> 6);
      default:   blk = (y & 12'hFC0) | ((x & 12'hFC0) >> 6);
    endcase
    r.word_index = {y[5:4], x[5:0]};
    r.bit_index  = y[3:0];
    owner = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (dir_valid[i] && dir_tag[i] == blk) begin
        owner = i;
        break;
      end
    end
    if (owner >= 0) begin
      r.hit = 1'b1;
    end else begin
      // Oldest slot wins; ties go to the lowest index and the scan stops once a new oldest slot
      // has age SLOTS-1.
      owner = 0;
      best = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (int'(dir_age[i]) > best) begin
          best = int'(dir_age[i]);
          owner = i;
          if (best == SLOTS - 1) break;
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (dir_age[i] != AGE_MAX) dir_age[i] = dir_age[i] + 1'b1;
      end
      dir_age[owner] = '0;
      if (dir_valid[owner] && dir_dirty[owner]) begin
        r.writeback = 1'b1;
        r.victim_block = dir_tag[owner];
      end
      r.fill_block = blk;
      dir_tag[owner] = blk;
      dir_valid[owner] = 1'b1;
      dir_dirty[owner] = 1'b0;
    end
    if (f == ACC_WRITE) dir_dirty[owner] = 1'b1;
    r.slot = owner[SLOT_W-1:0];
    return r;
  endfunction

  // Offers one access transaction and predicts its result once it is accepted. valid is left
  // high, so back-to-back accesses need no bubble.
  task automatic send_access(input logic f, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y);
    while (!steady && $urandom_range(99) < 32) begin
      acc_bus.valid <= 1'b0;
      @(posedge clk);
    end
    acc_bus.valid   <= 1'b1;
    acc_bus.func    <= f;
    acc_bus.x_coord <= x;
    acc_bus.y_coord <= y;
    @(posedge clk);
    while (!acc_bus.ready) @(posedge clk);
    pending_results.push_back(predict_lookup(f, x, y));
  endtask

  // Stops offering and waits until every predicted result has been delivered.
  task automatic drain_results();
    acc_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_LAYOUT_MODE) layout_q = data[MODE_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Reads layout_mode back and compares it with the shadow copy.
  task automatic cfg_check_layout();
    logic [APB_DATA_W-1:0] data;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_LAYOUT_MODE, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (data[MODE_W-1:0] !== layout_q) begin
      $display("%0t: layout_mode readback mismatch: expected %0d, actual %0d",
               $time, layout_q, data[MODE_W-1:0]);
      mismatches++;
    end
  endtask

  // Sets a layout with random junk in the unused data bits, then reads it back.
  task automatic set_layout(input logic [MODE_W-1:0] mode);
    logic [APB_DATA_W-1:0] data;
    data = $urandom;
    data[MODE_W-1:0] = mode;
    cfg_write(REG_LAYOUT_MODE, data);
    cfg_check_layout();
  endtask

  // Mostly revisits recent blocks with fresh word and bit offsets, so hits, dirty slots and
  // dirty evictions are all common; the rest are fully random coordinates.
  task automatic random_access();
    logic [11:0] key;
    logic [5:0]  lo_x;
    logic [5:0]  lo_y;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    lo_x = 6'($urandom_range(63));
    lo_y = 6'($urandom_range(63));
    if (recent_blocks.size() != 0 && $urandom_range(99) < 65) begin
      key = recent_blocks[$urandom_range(recent_blocks.size() - 1)];
      x = {key[11:6], lo_x};
      y = {key[5:0], lo_y};
    end else begin
      x = COORD_W'($urandom_range(4095));
      y = COORD_W'($urandom_range(4095));
      recent_blocks.push_back({x[11:6], y[11:6]});
      if (recent_blocks.size() > POOL_DEPTH) void'(recent_blocks.pop_front());
    end
    send_access($urandom_range(1) ? ACC_WRITE : ACC_READ, x, y);
  endtask

  // Register reset value and field extremes under the 1K layout: first fill, hit, write hit,
  // largest word and bit, and coordinates whose high bits the 1K layout must ignore.
  task automatic test_reset_and_fields();
    cfg_check_layout();
    send_access(ACC_READ,  12'h000, 12'h000);
    send_access(ACC_WRITE, 12'h000, 12'h000);
    send_access(ACC_READ,  12'hFFF, 12'hFFF);
    send_access(ACC_WRITE, 12'h03F, 12'h03F);
    send_access(ACC_READ,  12'hFC0, 12'hFC0);
    send_access(ACC_WRITE, 12'h555, 12'hAAA);
    send_access(ACC_READ,  12'hAAA, 12'h555);
    send_access(ACC_WRITE, 12'h3C0, 12'h000);
    drain_results();
  endtask

  // The 2K, 4K and unassigned layout codes, and a write to the empty register slot,
  // which must leave the layout as it was.
  task automatic test_layout_modes();
    set_layout(LAYOUT_2K);
    send_access(ACC_WRITE, 12'hFFF, 12'hFFF);
    send_access(ACC_READ,  12'h7C0, 12'h040);
    drain_results();
    set_layout(LAYOUT_4K);
    send_access(ACC_WRITE, 12'hFFF, 12'hFFF);
    send_access(ACC_READ,  12'hFC0, 12'h800);
    drain_results();
    set_layout(LAYOUT_SPARE);
    send_access(ACC_READ,  12'hFFF, 12'hFFF);
    send_access(ACC_WRITE, 12'h800, 12'hFC0);
    drain_results();
    cfg_write(REG_SPARE, {{(APB_DATA_W - MODE_W){1'b1}}, LAYOUT_1K});
    cfg_check_layout();
    send_access(ACC_WRITE, 12'hF40, 12'h7C0);
    drain_results();
  endtask

  // Random traffic in phases that walk through the layouts. One phase runs with no idling
  // on either side.
  task automatic test_random_traffic();
    logic [MODE_W-1:0] modes [6];
    modes = '{LAYOUT_2K, LAYOUT_1K, LAYOUT_SPARE, LAYOUT_4K, LAYOUT_1K, LAYOUT_2K};
    foreach (modes[p]) begin
      set_layout(modes[p]);
      steady = (p == 2);
      repeat (PHASE_ITEMS) random_access();
      drain_results();
    end
    steady = 1'b0;
  endtask

  // The sink holds off for a long stretch while accesses keep coming, so the output
  // register fills and the access channel must stall.
  task automatic test_backpressure();
    set_layout(LAYOUT_4K);
    hold_req = 1'b1;
    repeat (60) random_access();
    drain_results();
  endtask

  // The sender goes quiet until every result is in, then resumes.
  task automatic test_sender_pause();
    set_layout(LAYOUT_1K);
    repeat (30) random_access();
    drain_results();
    repeat (30) random_access();
    drain_results();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    acc_bus.valid = 1'b0;
    acc_bus.func = ACC_READ;
    acc_bus.x_coord = '0;
    acc_bus.y_coord = '0;
    mismatches = 0;
    cycle_count = 0;
    steady = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    layout_q = LAYOUT_1K;
    // Directory after reset: nothing valid or dirty, ages count down from SLOTS.
    for (int i = 0; i < SLOTS; i++) begin
      dir_tag[i] = '0;
      dir_valid[i] = 1'b0;
      dir_dirty[i] = 1'b0;
      dir_age[i] = age_t'(SLOTS - i);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_and_fields();
    test_layout_modes();
    test_random_traffic();
    test_backpressure();
    test_sender_pause();

    // Any stray result would show up in this window.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/bbcd_pkg.sv
hdl/bbcd_if.sv
hdl/bbcd_cfg.sv
hdl/bbcd_dir.sv
hdl/bitmap_block_cache_directory.sv
test/bitmap_block_cache_directory_tb.sv
